FILE: sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg: shared types for the rooted tree enumerator
// Datapath operation codes, register indexes and the status bundle returned
// to the controller.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam logic REG_NODE_COUNT   = 1'b0;
  localparam logic REG_DEGREE_LIMIT = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_START,
    OP_DLCHK,
    OP_FIRST,
    OP_NEXT,
    OP_TINIT,
    OP_TRDL,
    OP_TRST,
    OP_TRCC,
    OP_TINC,
    OP_TEND,
    OP_A0,
    OP_A1,
    OP_A2,
    OP_A3,
    OP_B0,
    OP_B1,
    OP_B2,
    OP_W0,
    OP_W1,
    OP_ERD,
    OP_ELD,
    OP_DLD
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic cp_nz;
    logic fail;
    logic j_last;
    logic pass;
    logic cond;
    logic p_lt;
    logic w_cont;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/rte_ctrl.sv
// ----------------------------------------------------------------------------
// rte_ctrl: sequencing state machine
// Steps the datapath through restart, successor steps, tree checks and
// result delivery, one operation per state.
// ----------------------------------------------------------------------------
module rte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                restart_i,
  output logic                in_stall_o,
  input  rte_pkg::dp_status_t status_i,
  output rte_pkg::dp_cmd_t    cmd_o
);
  import rte_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_START = 23'd1 << 1,
    S_DLCHK = 23'd1 << 2,
    S_FIRST = 23'd1 << 3,
    S_NEXT  = 23'd1 << 4,
    S_TINIT = 23'd1 << 5,
    S_TRDL  = 23'd1 << 6,
    S_TRST  = 23'd1 << 7,
    S_TRCC  = 23'd1 << 8,
    S_TINC  = 23'd1 << 9,
    S_TEND  = 23'd1 << 10,
    S_A0    = 23'd1 << 11,
    S_A1    = 23'd1 << 12,
    S_A2    = 23'd1 << 13,
    S_A3    = 23'd1 << 14,
    S_B0    = 23'd1 << 15,
    S_B1    = 23'd1 << 16,
    S_B2    = 23'd1 << 17,
    S_W0    = 23'd1 << 18,
    S_W1    = 23'd1 << 19,
    S_ERD   = 23'd1 << 20,
    S_ELD   = 23'd1 << 21,
    S_DLD   = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op = OP_IDLE;
        if (in_valid_i) begin
          state_d = restart_i ? S_START : S_DLCHK;
        end
      end
      S_START: begin
        cmd_o.op = OP_START;
        state_d = S_DLCHK;
      end
      S_DLCHK: begin
        cmd_o.op = OP_DLCHK;
        state_d = S_FIRST;
      end
      S_FIRST: begin
        cmd_o.op = OP_FIRST;
        if (!status_i.first) state_d = S_TINIT;
        else if (status_i.cp_nz) state_d = S_A0;
        else state_d = S_DLD;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        state_d = status_i.cp_nz ? S_A0 : S_DLD;
      end
      S_TINIT: begin
        cmd_o.op = OP_TINIT;
        state_d = S_TRDL;
      end
      S_TRDL: begin
        cmd_o.op = OP_TRDL;
        state_d = S_TRST;
      end
      S_TRST: begin
        cmd_o.op = OP_TRST;
        state_d = S_TRCC;
      end
      S_TRCC: begin
        cmd_o.op = OP_TRCC;
        state_d = S_TINC;
      end
      S_TINC: begin
        cmd_o.op = OP_TINC;
        if (status_i.fail) state_d = S_NEXT;
        else if (status_i.j_last) state_d = S_TEND;
        else state_d = S_TRDL;
      end
      S_TEND: begin
        cmd_o.op = OP_TEND;
        state_d = status_i.pass ? S_ERD : S_NEXT;
      end
      S_A0: begin
        cmd_o.op = OP_A0;
        state_d = S_A1;
      end
      S_A1: begin
        cmd_o.op = OP_A1;
        state_d = S_A2;
      end
      S_A2: begin
        cmd_o.op = OP_A2;
        state_d = status_i.cond ? S_A3 : S_W0;
      end
      S_A3: begin
        cmd_o.op = OP_A3;
        state_d = S_B0;
      end
      S_B0: begin
        cmd_o.op = OP_B0;
        state_d = status_i.p_lt ? S_B1 : S_W0;
      end
      S_B1: begin
        cmd_o.op = OP_B1;
        state_d = S_B2;
      end
      S_B2: begin
        cmd_o.op = OP_B2;
        state_d = S_B0;
      end
      S_W0: begin
        cmd_o.op = OP_W0;
        state_d = status_i.w_cont ? S_W1 : S_TINIT;
      end
      S_W1: begin
        cmd_o.op = OP_W1;
        state_d = S_W0;
      end
      S_ERD: begin
        cmd_o.op = OP_ERD;
        state_d = S_ELD;
      end
      S_ELD: begin
        cmd_o.op = OP_ELD;
        if (status_i.out_free) begin
          state_d = status_i.j_last ? S_IDLE : S_ERD;
        end
      end
      S_DLD: begin
        cmd_o.op = OP_DLD;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/rte_dp.sv
// ----------------------------------------------------------------------------
// rte_dp: level sequence datapath
// Holds the level sequence, its bookkeeping arrays, the parent map and child
// counts, the configuration registers and the output register.
// ----------------------------------------------------------------------------
module rte_dp #(
  parameter int MAX_NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [6:0]          cfg_data_i,
  input  rte_pkg::dp_cmd_t    cmd_i,
  output rte_pkg::dp_status_t status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [5:0]          node_index_o,
  output logic [5:0]          parent_o,
  output logic                last_o,
  output logic                done_res_o
);
  import rte_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int RST_NK = (MAX_NODES < 4) ? MAX_NODES : 4;
  localparam int RST_CP = (RST_NK >= 3) ? RST_NK - 1 : 0;

  function automatic logic [CNT_W-1:0] active_cnt(input logic [6:0] nc);
    logic [CMP_W-1:0] v;
    v = CMP_W'(nc);
    if (v < CMP_W'(2)) return CNT_W'(2);
    if (v > CMP_W'(MAX_NODES)) return CNT_W'(MAX_NODES);
    return CNT_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] start_cp(input logic [CNT_W-1:0] n);
    return (n >= CNT_W'(3)) ? IDX_W'(n - CNT_W'(1)) : '0;
  endfunction

  logic [6:0]       node_count_q;
  logic [5:0]       degree_limit_q;
  logic [IDX_W-1:0] cp_q, p_q, lv_q, diff_q, j_q, par_q, par_d;
  logic             first_q;
  logic [CNT_W-1:0] rootc_q, nk, cnt;
  logic [IDX_W-1:0] nkm1;

  // Storage
  logic [IDX_W-1:0] ls_mem [MAX_NODES];
  logic [IDX_W-1:0] lp_mem [MAX_NODES];
  logic [IDX_W-1:0] sp_mem [MAX_NODES];
  logic [IDX_W-1:0] st_mem [MAX_NODES];
  logic [IDX_W-1:0] pm_mem [MAX_NODES];
  logic [CNT_W-1:0] cc_mem [MAX_NODES];
  logic [MAX_NODES-1:0] ls_v_q, lp_v_q, sp_v_q, cc_v_q;

  logic [IDX_W-1:0] ls_ra_q, ls_rd_q, lp_ra_q, lp_rd_q, sp_rd_q, st_rd_q, pm_rd_q;
  logic [CNT_W-1:0] cc_rd_q;
  logic             ls_rv_q, lp_rv_q, sp_rv_q, cc_rv_q;
  logic [IDX_W-1:0] ls_r, lp_r, sp_r;
  logic [CNT_W-1:0] cc_r;

  logic             ls_re, lp_re, sp_re, st_re, pm_re, cc_re;
  logic [IDX_W-1:0] ls_raddr, lp_raddr, sp_raddr, st_raddr, pm_raddr, cc_raddr;
  logic             ls_we, lp_we, sp_we, st_we, pm_we, cc_we;
  logic [IDX_W-1:0] ls_wa, ls_wd, lp_wa, lp_wd, sp_wa, sp_wd, st_wa, st_wd, pm_wa, pm_wd;
  logic [IDX_W-1:0] cc_wa;
  logic [CNT_W-1:0] cc_wd;

  logic [IDX_W-1:0] dec, pn, src;
  logic             start, load_node, load_done, out_free;

  assign nk   = active_cnt(node_count_q);
  assign nkm1 = IDX_W'(nk - CNT_W'(1));

  // Entries unwritten since restart (cc_mem: since TINIT) read as reset value
  assign ls_r = ls_rv_q ? ls_rd_q : ls_ra_q;
  assign lp_r = lp_rv_q ? lp_rd_q : lp_ra_q;
  assign sp_r = sp_rv_q ? sp_rd_q : '0;
  assign cc_r = cc_rv_q ? cc_rd_q : '0;

  assign dec   = (ls_r != '0) ? ls_r - IDX_W'(1) : ls_r;
  assign pn    = p_q + IDX_W'(1);
  assign src   = (pn >= diff_q) ? pn - diff_q : '0;
  assign par_d = (lv_q != '0) ? st_rd_q : '0;
  assign cnt   = cc_r + CNT_W'(1);

  assign out_free  = !out_valid_o || !out_stall_i;
  assign load_node = (cmd_i.op == OP_ELD) && out_free;
  assign load_done = (cmd_i.op == OP_DLD) && out_free;
  assign start     = (cmd_i.op == OP_START) || (cfg_we_i && (cfg_idx_i == REG_NODE_COUNT));

  assign status_o.first    = first_q;
  assign status_o.cp_nz    = (cp_q != '0);
  assign status_o.fail     = (par_q != '0) && (CMP_W'(cnt) > CMP_W'(degree_limit_q));
  assign status_o.j_last   = (j_q == nkm1);
  assign status_o.pass     = (CMP_W'(rootc_q) < CMP_W'(degree_limit_q));
  assign status_o.cond     = (p_q < nkm1) && (p_q != '0) &&
                             ((lv_q != IDX_W'(1)) || (ls_r != IDX_W'(1)));
  assign status_o.p_lt     = (p_q < nkm1);
  assign status_o.w_cont   = (p_q != '0) && (lv_q == IDX_W'(1));
  assign status_o.out_free = out_free;

  always_comb begin
    ls_re = 1'b0; ls_raddr = j_q;
    lp_re = 1'b0; lp_raddr = lv_q;
    sp_re = 1'b0; sp_raddr = p_q - IDX_W'(1);
    st_re = 1'b0; st_raddr = ls_r - IDX_W'(1);
    pm_re = 1'b0; pm_raddr = j_q;
    cc_re = 1'b0; cc_raddr = par_d;
    ls_we = 1'b0; ls_wa = p_q;  ls_wd = dec;
    lp_we = 1'b0; lp_wa = lv_q; lp_wd = p_q;
    sp_we = 1'b0; sp_wa = p_q;  sp_wd = lp_r;
    st_we = 1'b0; st_wa = lv_q; st_wd = j_q;
    pm_we = 1'b0; pm_wa = j_q;  pm_wd = par_q;
    cc_we = 1'b0; cc_wa = par_q; cc_wd = cnt;
    case (cmd_i.op)
      OP_TINIT: begin
        st_we = 1'b1; st_wa = '0; st_wd = '0;
        pm_we = 1'b1; pm_wa = '0; pm_wd = '0;
      end
      OP_TRDL: ls_re = 1'b1;
      OP_TRST: st_re = 1'b1;
      OP_TRCC: cc_re = 1'b1;
      OP_TINC: begin
        if (!status_o.fail) begin
          st_we = 1'b1;
          pm_we = 1'b1;
        end
        cc_we = (par_q != '0);
      end
      OP_A0: begin
        ls_re = 1'b1; ls_raddr = cp_q;
      end
      OP_A1: begin
        ls_we = 1'b1;
        ls_re = 1'b1; ls_raddr = p_q - IDX_W'(1);
      end
      OP_A2: lp_re = 1'b1;
      OP_B0: lp_re = 1'b1;
      OP_B1: begin
        sp_we = 1'b1;
        lp_we = 1'b1;
        ls_re = 1'b1; ls_raddr = src;
      end
      OP_B2: begin
        ls_we = 1'b1; ls_wd = ls_r;
      end
      OP_W0: begin
        if (status_o.w_cont) begin
          ls_re = 1'b1; ls_raddr = p_q - IDX_W'(1);
          sp_re = 1'b1;
        end
      end
      OP_W1: begin
        lp_we = 1'b1; lp_wa = ls_r; lp_wd = sp_r;
      end
      OP_ERD: pm_re = 1'b1;
      default: ;
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[ls_wa] <= ls_wd;
    if (lp_we) lp_mem[lp_wa] <= lp_wd;
    if (sp_we) sp_mem[sp_wa] <= sp_wd;
    if (st_we) st_mem[st_wa] <= st_wd;
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    if (cc_we) cc_mem[cc_wa] <= cc_wd;
    if (ls_re) ls_rd_q <= ls_mem[ls_raddr];
    if (lp_re) lp_rd_q <= lp_mem[lp_raddr];
    if (sp_re) sp_rd_q <= sp_mem[sp_raddr];
    if (st_re) st_rd_q <= st_mem[st_raddr];
    if (pm_re) pm_rd_q <= pm_mem[pm_raddr];
    if (cc_re) cc_rd_q <= cc_mem[cc_raddr];
    if (ls_re) ls_ra_q <= ls_raddr;
    if (lp_re) lp_ra_q <= lp_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_v_q  <= '0;
      lp_v_q  <= '0;
      sp_v_q  <= '0;
      cc_v_q  <= '0;
      ls_rv_q <= 1'b0;
      lp_rv_q <= 1'b0;
      sp_rv_q <= 1'b0;
      cc_rv_q <= 1'b0;
    end else begin
      if (ls_re) ls_rv_q <= ls_v_q[ls_raddr] || (ls_we && ls_wa == ls_raddr);
      if (lp_re) lp_rv_q <= lp_v_q[lp_raddr];
      if (sp_re) sp_rv_q <= sp_v_q[sp_raddr];
      if (cc_re) cc_rv_q <= cc_v_q[cc_raddr];
      if (start) begin
        ls_v_q <= '0;
        lp_v_q <= '0;
        sp_v_q <= '0;
      end else begin
        if (ls_we) ls_v_q[ls_wa] <= 1'b1;
        if (lp_we) lp_v_q[lp_wa] <= 1'b1;
        if (sp_we) sp_v_q[sp_wa] <= 1'b1;
      end
      if (cmd_i.op == OP_TINIT) cc_v_q <= '0;
      else if (cc_we) cc_v_q[cc_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= 7'd4;
      degree_limit_q <= 6'd2;
      cp_q           <= IDX_W'(RST_CP);
      first_q        <= 1'b0;
      out_valid_o    <= 1'b0;
      p_q            <= '0;
      lv_q           <= '0;
      diff_q         <= '0;
      j_q            <= '0;
      par_q          <= '0;
      rootc_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NODE_COUNT) begin
          node_count_q <= cfg_data_i;
          cp_q         <= start_cp(active_cnt(cfg_data_i));
          first_q      <= 1'b0;
        end else begin
          degree_limit_q <= cfg_data_i[5:0];
        end
      end
      if (load_node || load_done) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      case (cmd_i.op)
        OP_START: begin
          cp_q    <= start_cp(nk);
          first_q <= 1'b0;
        end
        OP_DLCHK: begin
          if (degree_limit_q < 6'd2) begin
            cp_q    <= '0;
            first_q <= 1'b1;
          end
        end
        OP_FIRST: first_q <= 1'b1;
        OP_TINIT: begin
          rootc_q <= '0;
          j_q     <= IDX_W'(1);
        end
        OP_TRST: lv_q <= ls_r;
        OP_TRCC: par_q <= par_d;
        OP_TINC: begin
          if (par_q == '0) rootc_q <= rootc_q + CNT_W'(1);
          j_q <= j_q + IDX_W'(1);
        end
        OP_TEND: j_q <= '0;
        OP_A0: p_q <= cp_q;
        OP_A1: lv_q <= dec;
        OP_A3: diff_q <= (p_q > lp_r) ? p_q - lp_r : IDX_W'(1);
        OP_B1: p_q <= pn;
        OP_B2: lv_q <= ls_r;
        OP_W0: begin
          if (status_o.w_cont) p_q <= p_q - IDX_W'(1);
          else cp_q <= p_q;
        end
        OP_W1: lv_q <= ls_r;
        OP_ELD: if (out_free) j_q <= j_q + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_node) begin
      node_index_o <= 6'(j_q);
      parent_o     <= 6'(pm_rd_q);
      last_o       <= (j_q == nkm1);
      done_res_o   <= 1'b0;
    end else if (load_done) begin
      node_index_o <= '0;
      parent_o     <= '0;
      last_o       <= 1'b1;
      done_res_o   <= 1'b1;
    end
  end

endmodule

FILE: sv/rooted_tree_enumerator_top.sv
// ----------------------------------------------------------------------------
// rooted_tree_enumerator_top: rooted tree enumerator
// Each request delivers the parent of every node of the next accepted rooted
// tree in level sequence order, or a single done result once exhausted.
// ----------------------------------------------------------------------------
// A request is handled one at a time: the block stalls its input until the
// whole request has been worked off. A tree check walks every non-root node
// in turn; a successor step may rewrite the tail position by position and
// backtrack position by position, and each result then waits until the
// output is free. A request that skips rejected trees costs one successor
// step and one check per skipped tree. Writing node_count restarts the
// enumeration at once; no clearing pass is needed.
module rooted_tree_enumerator_top #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] node_index_o,
  output logic [5:0] parent_o,
  output logic       last_o,
  output logic       done_res_o
);
  import rte_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rte_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .node_index_o (node_index_o),
    .parent_o     (parent_o),
    .last_o       (last_o),
    .done_res_o   (done_res_o)
  );

endmodule

FILE: tb/rooted_tree_enumerator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rooted_tree_enumerator_top_test: self-checking bench for the tree enumerator
// Drives next/restart requests under random idling and long output hold-off,
// predicts every parent report and done marker from a behavioral copy of the
// level sequence walk, and compares each result field by field.
// ----------------------------------------------------------------------------
module rooted_tree_enumerator_top_test;
  import rte_pkg::*;

  localparam int  MAX_NODES        = 64;
  localparam int  CYCLE_LIMIT      = 1500000;
  localparam int  HOLD_CYCLES      = 600;
  localparam int  DRAIN_CYCLES     = 200;

  typedef struct packed {
    logic [5:0] node_index;
    logic [5:0] parent;
    logic       last;
    logic       done_res;
  } report_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = 1'b0;
  logic [6:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       restart_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [5:0] node_index_o;
  logic [5:0] parent_o;
  logic       last_o;
  logic       done_res_o;

  rooted_tree_enumerator_top #(.MAX_NODES(MAX_NODES)) dut (.*);

  // behavioral copy of the enumerator state
  int         lvl_seq   [MAX_NODES];
  int         last_pos  [MAX_NODES];
  int         saved_pos [MAX_NODES];
  int         par_map   [MAX_NODES];
  int         kids      [MAX_NODES];
  int         anc_stack [MAX_NODES];
  int         chg_ptr;
  bit         first_out;
  logic [6:0] node_count_q;
  logic [5:0] degree_limit_q;

  bit      request_q[$];
  report_t expected_reports[$];

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  bit hold_go   = 1'b0;
  bit hold_on   = 1'b0;
  int hold_left = 0;
  int mismatches    = 0;
  int reports_seen  = 0;
  int trees_seen    = 0;
  int dones_seen    = 0;
  int requests_sent = 0;
  int cycles        = 0;

  function automatic int clip_idx(int x);
    return x < MAX_NODES ? x : MAX_NODES - 1;
  endfunction

  function automatic int active_nodes();
    if (node_count_q < 2) return 2;
    if (node_count_q > MAX_NODES) return MAX_NODES;
    return int'(node_count_q);
  endfunction

  function automatic void restart_walk();
    int nk;
    nk = active_nodes();
    for (int i = 0; i < MAX_NODES; i++) begin
      lvl_seq[i]   = i;
      last_pos[i]  = i;
      saved_pos[i] = 0;
    end
    chg_ptr   = nk >= 3 ? nk - 1 : 0;
    first_out = 1'b0;
  endfunction

  function automatic bit tree_accepted();
    int nk, lv, p;
    nk = active_nodes();
    for (int i = 0; i < MAX_NODES; i++) kids[i] = 0;
    par_map[0]   = 0;
    anc_stack[0] = 0;
    for (int j = 1; j < nk; j++) begin
      lv = clip_idx(lvl_seq[j]);
      p  = lv > 0 ? clip_idx(anc_stack[lv - 1]) : 0;
      kids[p]++;
      if (p != 0 && kids[p] > degree_limit_q) return 1'b0;
      par_map[j]    = p;
      anc_stack[lv] = j;
    end
    return kids[0] < degree_limit_q;
  endfunction

  function automatic void next_sequence();
    int nk, p, lv, from, diff;
    nk = active_nodes();
    p  = clip_idx(chg_ptr);
    if (lvl_seq[p] > 0) lvl_seq[p]--;
    if (p < nk - 1 && p > 0 && (lvl_seq[p] != 1 || lvl_seq[p - 1] != 1)) begin
      from = clip_idx(last_pos[clip_idx(lvl_seq[p])]);
      diff = p > from ? p - from : 1;
      while (p < nk - 1) begin
        lv           = clip_idx(lvl_seq[p]);
        saved_pos[p] = last_pos[lv];
        last_pos[lv] = p;
        p++;
        lvl_seq[p] = lvl_seq[p >= diff ? p - diff : 0];
      end
    end
    while (p > 0 && lvl_seq[p] == 1) begin
      p--;
      last_pos[clip_idx(lvl_seq[p])] = saved_pos[p];
    end
    chg_ptr = p;
  endfunction

  function automatic void queue_tree();
    int nk;
    report_t r;
    nk = active_nodes();
    for (int i = 0; i < nk; i++) begin
      r.node_index = i[5:0];
      r.parent     = par_map[i][5:0];
      r.last       = (i == nk - 1);
      r.done_res   = 1'b0;
      expected_reports.push_back(r);
    end
  endfunction

  function automatic void predict_request(bit restart);
    report_t r;
    if (restart) restart_walk();
    if (degree_limit_q < 2) begin
      chg_ptr   = 0;
      first_out = 1'b1;
    end
    if (!first_out) begin
      first_out = 1'b1;
      if (tree_accepted()) begin
        queue_tree();
        return;
      end
    end
    while (chg_ptr > 0) begin
      next_sequence();
      if (tree_accepted()) begin
        queue_tree();
        return;
      end
    end
    r = '{node_index: 6'd0, parent: 6'd0, last: 1'b1, done_res: 1'b1};
    expected_reports.push_back(r);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i) begin
    bit nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_request(request_q.pop_front());
        requests_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && request_q.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt_valid = 1'b1;
        restart_i <= request_q[0];
      end
      in_valid_i <= nxt_valid;
    end
  end

  // long output hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_go && !hold_on && hold_left == 0) begin
      hold_on   <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_on) begin
      if (hold_left == 1) hold_on <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{node_index: node_index_o, parent: parent_o,
                last: last_o, done_res: done_res_o};
        reports_seen++;
        if (got.done_res) dones_seen++;
        else if (got.last) trees_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result node %0d parent %0d last %0d done %0d",
                     got.node_index, got.parent, got.last, got.done_res);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp node %0d parent %0d last %0d done %0d, got %0d %0d %0d %0d",
                       want.node_index, want.parent, want.last, want.done_res,
                       got.node_index, got.parent, got.last, got.done_res);
          end
        end
      end
      out_stall_i <= hold_on || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid_i || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, logic [6:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_NODE_COUNT) begin
      node_count_q = value;
      restart_walk();
    end else begin
      degree_limit_q = value[5:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(bit restart, int count);
    for (int i = 0; i < count; i++) request_q.push_back(restart);
  endtask

  initial begin
    int n_sel, d_sel;
    node_count_q   = 7'd4;
    degree_limit_q = 6'd2;
    for (int i = 0; i < MAX_NODES; i++) begin
      par_map[i]   = 0;
      anc_stack[i] = 0;
      kids[i]      = 0;
    end
    restart_walk();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings until exhausted, then restart
    sender_idle_pct   = 26;
    receiver_idle_pct = 71;
    send(1'b0, 5);
    send(1'b1, 1);
    send(1'b0, 1);
    wait_idle();
    write_reg(REG_NODE_COUNT, 7'd2);
    send(1'b0, 2);
    wait_idle();
    write_reg(REG_NODE_COUNT, 7'd0);
    send(1'b0, 2);
    send(1'b1, 1);
    wait_idle();
    write_reg(REG_NODE_COUNT, 7'd127);
    write_reg(REG_DEGREE_LIMIT, 7'd63);
    send(1'b0, 3);
    wait_idle();
    write_reg(REG_DEGREE_LIMIT, 7'd2);
    send(1'b1, 1);
    send(1'b0, 2);
    wait_idle();
    write_reg(REG_NODE_COUNT, 7'd1);
    write_reg(REG_DEGREE_LIMIT, 7'd0);
    send(1'b1, 1);
    wait_idle();
    write_reg(REG_NODE_COUNT, 7'd5);
    write_reg(REG_DEGREE_LIMIT, 7'd1);
    send(1'b0, 1);
    send(1'b1, 1);
    wait_idle();

    // random phases of small trees and varied degree limits
    for (int ph = 0; ph < 9; ph++) begin
      sender_idle_pct   = ph < 3 ? 26 : (ph < 6 ? 71 : 0);
      receiver_idle_pct = ph < 3 ? 71 : (ph < 6 ? 26 : 0);
      n_sel = $urandom_range(9);
      d_sel = $urandom_range(9);
      write_reg(REG_NODE_COUNT, n_sel == 0 ? 7'($urandom_range(1))
                               : 7'($urandom_range(8, 3)));
      write_reg(REG_DEGREE_LIMIT, d_sel == 0 ? 7'($urandom_range(63))
                                 : 7'($urandom_range(4, 2)));
      if (ph == 6) hold_go = 1'b1;
      for (int k = 0; k < 11; k++) send($urandom_range(99) < 20, 1);
      wait_idle();
      hold_go = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d trees, %0d done markers, %0d reports checked",
             requests_sent, trees_seen, dones_seen, reports_seen);
    $display("exercised clamped node counts, exhaustion and restart, tiny degree limits, and long output hold-off");
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rte_pkg.sv
sv/rte_ctrl.sv
sv/rte_dp.sv
sv/rooted_tree_enumerator_top.sv
tb/rooted_tree_enumerator_top_test.sv
